// ===== hdl/strip_vertex_normal_accumulator_unit_macros.svh =====
// assertion helpers for the strip vertex normal accumulator
`ifndef STRIP_VERTEX_NORMAL_ACCUMULATOR_UNIT_MACROS_SVH
`define STRIP_VERTEX_NORMAL_ACCUMULATOR_UNIT_MACROS_SVH
`ifndef SYNTH
`define SVNA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svna assertion failed");
`define SVNA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svna assertion failed");
`else
`define SVNA_ASSERT_IMP(lbl, ante, cons)
`define SVNA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/svna_pkg.sv =====
`default_nettype none
package svna_pkg;

  localparam int VERTEX_DEPTH = 4096;
  localparam int IDX_W        = $clog2(VERTEX_DEPTH);
  localparam int POS_W        = 24;
  localparam int EDGE_W       = POS_W + 1;
  localparam int MUL_W        = 31;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int GAIN_W       = 4;
  localparam int CROSS_W      = 56;
  localparam int MAG_W        = CROSS_W - 1;
  localparam int NORM_BITS    = 30;
  localparam int FRAC_W       = 14;
  localparam int SQ_W         = 63;
  localparam int LEN_W        = 32;
  localparam int NUM_W        = 46;
  localparam int DCNT_W       = $clog2(NUM_W + 1);
  localparam int SUM_W        = 23;
  localparam int HIT_W        = 8;
  localparam int NRM_W        = 16;
  localparam int ENTRY_W      = 3 * SUM_W + HIT_W;
  localparam int IN_DATA_W    = 88;
  localparam int IN_USER_W    = 3;
  localparam int OUT_DATA_W   = 56;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd5;
  localparam logic [HIT_W-1:0]  HIT_MAX    = 8'hFF;
  localparam logic [HIT_W-1:0]  HIT_ONE    = 8'd1;

  typedef enum logic [1:0] {
    OP_VERTEX = 2'd0,
    OP_FINAL  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [HIT_W-1:0]        hit;
    logic signed [SUM_W-1:0] sz;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] sx;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// ===== hdl/svna_ram.sv =====
`default_nettype none
module svna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/svna_div.sv =====
`default_nettype none
module svna_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [svna_pkg::NUM_W-1:0] num,
  input  wire logic [svna_pkg::LEN_W-1:0] den,
  output svna_pkg::div_stat_t             stat,
  output logic      [svna_pkg::NUM_W-1:0] quot
);
  import svna_pkg::*;

  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [LEN_W:0]    rem_r, rem_nxt;
  logic [LEN_W-1:0]  den_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [LEN_W:0]    shifted;
  logic [LEN_W+1:0]  trial;

  // restoring division, one quotient bit a cycle
  always_comb begin
    shifted = {rem_r[LEN_W-1:0], quo_r[NUM_W-1]};
    trial   = {1'b0, shifted} - {2'b00, den_r};
    if (!trial[LEN_W+1]) begin
      rem_nxt = trial[LEN_W:0];
      quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted;
      quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quo_r;

endmodule
`default_nettype wire

// ===== hdl/strip_vertex_normal_accumulator_unit.sv =====
`default_nettype none
// Accumulates averaged vertex normals from triangle-strip vertices into a 4096-entry
// store and returns the averaged normal on a finalize word. After reset the block
// runs a clearing pass over every entry with in_tready low. A skipped strip vertex,
// a clear word and an unused opcode are taken without leaving the idle state. A
// full triangle runs six cross-product terms and three squares on one shared 31x31
// multiplier, up to 25 shifts, a 32-step square root, three 46-step divides on one
// shared bit-serial divider and three read-modify-writes of the store. A finalize
// with a hit count above one divides the sums by it on the same divider. The user
// must write z_gain through cfg_wr_en and cfg_wr_data only while the block is idle;
// the block itself does not enforce this.
`include "strip_vertex_normal_accumulator_unit_macros.svh"
module strip_vertex_normal_accumulator_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [svna_pkg::GAIN_W-1:0]    cfg_wr_data,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // vertex_index, pos_x, pos_y, pos_z, zero pad
  input  wire logic [svna_pkg::IN_DATA_W-1:0] in_tdata,
  // opcode, first_of_strip
  input  wire logic [svna_pkg::IN_USER_W-1:0] in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // normal_x, normal_y, normal_z, hits_before
  output logic [svna_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import svna_pkg::*;

  typedef enum logic [14:0] {
    S_CLR   = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_MUL   = 15'b000000000000100,
    S_GAIN  = 15'b000000000001000,
    S_ABS   = 15'b000000000010000,
    S_NORM  = 15'b000000000100000,
    S_SQ    = 15'b000000001000000,
    S_SQRT  = 15'b000000010000000,
    S_DIVGO = 15'b000000100000000,
    S_DIVWT = 15'b000001000000000,
    S_ARD   = 15'b000010000000000,
    S_AWR   = 15'b000100000000000,
    S_FCHK  = 15'b001000000000000,
    S_FWR   = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

  state_t state_r;

  logic [GAIN_W-1:0] zgain_r;

  // input decode
  op_t                     in_op;
  logic                    in_first;
  logic [IDX_W-1:0]        in_idx;
  logic signed [POS_W-1:0] in_pos [3];
  logic                    in_acc;

  // strip history
  logic [IDX_W-1:0]        old_idx_r, new_idx_r;
  logic signed [POS_W-1:0] old_pos_r [3];
  logic signed [POS_W-1:0] new_pos_r [3];
  logic                    flip_r;

  logic [IDX_W-1:0]        eo_idx, en_idx;
  logic                    eflip;
  logic signed [POS_W-1:0] eo_pos [3];
  logic signed [POS_W-1:0] en_pos [3];
  logic signed [POS_W-1:0] pa [3];
  logic signed [POS_W-1:0] pb [3];
  logic signed [EDGE_W-1:0] e1 [3];
  logic signed [EDGE_W-1:0] e2 [3];

  // datapath
  logic signed [EDGE_W-1:0]  e1_r [3];
  logic signed [EDGE_W-1:0]  e2_r [3];
  logic signed [CROSS_W-1:0] c_r [3];
  logic [MAG_W-1:0]          mag_r [3];
  logic                      neg_r [3];
  logic [SQ_W-1:0]           sq_r, rt_r, bit_r, sq_t;
  logic signed [SUM_W-1:0]   res_r [3];
  logic [IDX_W-1:0]          acc_idx_r [3];
  logic [IDX_W-1:0]          fidx_r;
  entry_t                    ent_r;
  logic                      fin_r;
  logic [2:0]                j_r;
  logic [1:0]                k_r;
  logic [IDX_W-1:0]          clr_cnt_r;
  logic                      out_valid_r;
  logic [OUT_DATA_W-1:0]     out_data_r;

  logic signed [MUL_W-1:0]          mul_a, mul_b;
  logic signed [PROD_W-1:0]         mul_p;
  logic signed [CROSS_W-1:0]        prod_c;
  logic signed [CROSS_W+GAIN_W:0]   gprod;
  logic signed [CROSS_W-1:0]        cabs [3];
  logic                             big_any;
  logic                             c_zero;

  logic signed [SUM_W-1:0] ent_sum [3];
  logic [SUM_W-1:0]        sabs;
  logic                    neg_sel;
  logic [SUM_W-1:0]        qv;

  // shared divider
  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic [LEN_W-1:0]   div_den;
  div_stat_t          div_stat;
  logic [NUM_W-1:0]   div_q;

  // store
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  entry_t             ram_rd, ram_wr;

  assign in_op    = op_t'(in_tuser[1:0]);
  assign in_first = in_tuser[2];
  assign in_idx   = in_tdata[IDX_W-1:0];
  assign in_pos[0] = signed'(in_tdata[35:12]);
  assign in_pos[1] = signed'(in_tdata[59:36]);
  assign in_pos[2] = signed'(in_tdata[83:60]);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign ram_rd    = entry_t'(ram_rdata);

  always_comb begin
    eo_idx = in_first ? in_idx : old_idx_r;
    en_idx = in_first ? in_idx : new_idx_r;
    eflip  = in_first ? 1'b0 : flip_r;
    for (int k = 0; k < 3; k++) begin
      eo_pos[k] = in_first ? in_pos[k] : old_pos_r[k];
      en_pos[k] = in_first ? in_pos[k] : new_pos_r[k];
      pa[k]     = eflip ? en_pos[k] : eo_pos[k];
      pb[k]     = eflip ? eo_pos[k] : en_pos[k];
      e1[k]     = {pb[k][POS_W-1], pb[k]} - {pa[k][POS_W-1], pa[k]};
      e2[k]     = {in_pos[k][POS_W-1], in_pos[k]} - {pa[k][POS_W-1], pa[k]};
    end
  end

  // shared multiplier: cross product terms, then squares of the magnitudes
  always_comb begin
    if (state_r == S_MUL) begin
      case (j_r)
        3'd0: begin mul_a = MUL_W'(e1_r[1]); mul_b = MUL_W'(e2_r[2]); end
        3'd1: begin mul_a = MUL_W'(e1_r[2]); mul_b = MUL_W'(e2_r[1]); end
        3'd2: begin mul_a = MUL_W'(e1_r[2]); mul_b = MUL_W'(e2_r[0]); end
        3'd3: begin mul_a = MUL_W'(e1_r[0]); mul_b = MUL_W'(e2_r[2]); end
        3'd4: begin mul_a = MUL_W'(e1_r[0]); mul_b = MUL_W'(e2_r[1]); end
        default: begin mul_a = MUL_W'(e1_r[1]); mul_b = MUL_W'(e2_r[0]); end
      endcase
    end else begin
      mul_a = signed'({1'b0, mag_r[k_r][NORM_BITS-1:0]});
      mul_b = signed'({1'b0, mag_r[k_r][NORM_BITS-1:0]});
    end
    mul_p  = mul_a * mul_b;
    prod_c = signed'(mul_p[CROSS_W-1:0]);
    gprod  = c_r[2] * signed'({1'b0, zgain_r});
  end

  always_comb begin
    big_any = 1'b0;
    c_zero  = 1'b1;
    for (int k = 0; k < 3; k++) begin
      cabs[k] = c_r[k][CROSS_W-1] ? -c_r[k] : c_r[k];
      if (|mag_r[k][MAG_W-1:NORM_BITS]) big_any = 1'b1;
      if (c_r[k] != '0) c_zero = 1'b0;
    end
    sq_t = rt_r + bit_r;
  end

  // divider operands
  always_comb begin
    ent_sum[0] = ent_r.sx;
    ent_sum[1] = ent_r.sy;
    ent_sum[2] = ent_r.sz;
    sabs       = ent_sum[k_r][SUM_W-1] ? SUM_W'(-ent_sum[k_r]) : SUM_W'(ent_sum[k_r]);
    neg_sel    = fin_r ? ent_sum[k_r][SUM_W-1] : neg_r[k_r];
    div_start  = (state_r == S_DIVGO);
    if (fin_r) begin
      div_num = {{(NUM_W-SUM_W){1'b0}}, sabs}
              + {{(NUM_W-HIT_W+1){1'b0}}, ent_r.hit[HIT_W-1:1]};
      div_den = {{(LEN_W-HIT_W){1'b0}}, ent_r.hit};
    end else begin
      div_num = {2'b00, mag_r[k_r][NORM_BITS-1:0], {FRAC_W{1'b0}}}
              + {{(NUM_W-LEN_W+1){1'b0}}, rt_r[LEN_W-1:1]};
      div_den = rt_r[LEN_W-1:0];
    end
    qv = div_q[SUM_W-1:0];
  end

  // store port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = acc_idx_r[k_r];
    ram_wr    = '0;
    ram_raddr = acc_idx_r[k_r];
    case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
      end
      S_IDLE: begin
        ram_raddr = in_idx;
        ram_waddr = in_idx;
        ram_we    = in_acc && (in_op == OP_CLEAR);
      end
      S_AWR: begin
        ram_we    = (ram_rd.hit != HIT_MAX);
        ram_wr.hit = ram_rd.hit + 1'b1;
        ram_wr.sx  = ram_rd.sx + res_r[0];
        ram_wr.sy  = ram_rd.sy + res_r[1];
        ram_wr.sz  = ram_rd.sz + res_r[2];
      end
      S_FWR: begin
        ram_we     = 1'b1;
        ram_waddr  = fidx_r;
        ram_wr.hit = HIT_ONE;
        ram_wr.sx  = res_r[0];
        ram_wr.sy  = res_r[1];
        ram_wr.sz  = res_r[2];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    ram_wdata = ram_wr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zgain_r <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      zgain_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      old_idx_r   <= '0;
      new_idx_r   <= '0;
      flip_r      <= 1'b0;
      fin_r       <= 1'b0;
      j_r         <= '0;
      k_r         <= '0;
      for (int k = 0; k < 3; k++) begin
        old_pos_r[k] <= '0;
        new_pos_r[k] <= '0;
      end
    end else begin
      if (out_valid_r && out_tready && (state_r != S_OUT)) out_valid_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (&clr_cnt_r) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            case (in_op)
              OP_VERTEX: begin
                flip_r    <= !eflip;
                old_idx_r <= en_idx;
                new_idx_r <= in_idx;
                for (int k = 0; k < 3; k++) begin
                  old_pos_r[k] <= en_pos[k];
                  new_pos_r[k] <= in_pos[k];
                  e1_r[k]      <= e1[k];
                  e2_r[k]      <= e2[k];
                end
                acc_idx_r[0] <= eo_idx;
                acc_idx_r[1] <= en_idx;
                acc_idx_r[2] <= in_idx;
                fin_r        <= 1'b0;
                j_r          <= '0;
                // a triangle whose newest vertex repeats the oldest is dropped
                if (in_idx != eo_idx) state_r <= S_MUL;
              end
              OP_FINAL: begin
                fidx_r  <= in_idx;
                state_r <= S_FCHK;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_MUL: begin
          if (!j_r[0]) c_r[j_r[2:1]] <= prod_c;
          else         c_r[j_r[2:1]] <= c_r[j_r[2:1]] - prod_c;
          j_r <= j_r + 1'b1;
          if (j_r == 3'd5) state_r <= S_GAIN;
        end
        S_GAIN: begin
          c_r[2]  <= signed'(gprod[CROSS_W-1:0]);
          state_r <= S_ABS;
        end
        S_ABS: begin
          for (int k = 0; k < 3; k++) begin
            neg_r[k] <= c_r[k][CROSS_W-1];
            mag_r[k] <= cabs[k][MAG_W-1:0];
          end
          sq_r    <= '0;
          k_r     <= '0;
          state_r <= c_zero ? S_IDLE : S_NORM;
        end
        S_NORM: begin
          if (big_any) begin
            for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 1;
          end else begin
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          sq_r <= sq_r + {1'b0, mul_p[PROD_W-1:0]};
          if (k_r == 2'd2) begin
            k_r     <= '0;
            rt_r    <= '0;
            bit_r   <= {1'b1, {(SQ_W-1){1'b0}}};
            state_r <= S_SQRT;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_SQRT: begin
          if (sq_r >= sq_t) begin
            sq_r <= sq_r - sq_t;
            rt_r <= (rt_r >> 1) + bit_r;
          end else begin
            rt_r <= rt_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) state_r <= S_DIVGO;
        end
        S_DIVGO: begin
          if (!fin_r && rt_r == '0) state_r <= S_IDLE;
          else                      state_r <= S_DIVWT;
        end
        S_DIVWT: begin
          if (div_stat.done) begin
            res_r[k_r] <= neg_sel ? signed'(-qv) : signed'(qv);
            if (k_r == 2'd2) begin
              k_r     <= '0;
              state_r <= fin_r ? S_FWR : S_ARD;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_DIVGO;
            end
          end
        end
        S_ARD: begin
          state_r <= S_AWR;
        end
        S_AWR: begin
          if (k_r == 2'd2) begin
            k_r     <= '0;
            state_r <= S_IDLE;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_ARD;
          end
        end
        S_FCHK: begin
          ent_r    <= ram_rd;
          res_r[0] <= ram_rd.sx;
          res_r[1] <= ram_rd.sy;
          res_r[2] <= ram_rd.sz;
          k_r      <= '0;
          fin_r    <= 1'b1;
          state_r  <= (ram_rd.hit > HIT_ONE) ? S_DIVGO : S_OUT;
        end
        S_FWR: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {ent_r.hit, res_r[2][NRM_W-1:0], res_r[1][NRM_W-1:0],
                            res_r[0][NRM_W-1:0]};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  svna_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quot  (div_q)
  );

  svna_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (VERTEX_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `SVNA_ASSERT_IMP(a_div_start_idle, div_start, !div_stat.busy)
  `SVNA_ASSERT_IMP(a_sqrt_bit_onehot, state_r == S_SQRT, $onehot(bit_r))
  `SVNA_ASSERT_NXT(a_final_busy, in_acc && in_op == OP_FINAL, !in_tready)
  `SVNA_ASSERT_IMP(a_acc_hit_nonzero, ram_we && state_r == S_AWR, ram_wr.hit != '0)

endmodule
`default_nettype wire

// ===== dv/svna_normal_checker.sv =====
`default_nettype none
module svna_normal_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [svna_pkg::GAIN_W-1:0]    cfg_wr_data,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  input  wire logic [svna_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic [svna_pkg::IN_USER_W-1:0] in_tuser,
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic [svna_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                                  errors,
  output int                                  pending,
  output int                                  checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import svna_pkg::*;

  // packed from the top bit down: hits in the highest byte, normal_x lowest
  typedef struct packed {
    logic [7:0]  hits;
    logic [15:0] nz;
    logic [15:0] ny;
    logic [15:0] nx;
  } normal_word_t;

  int               acc_x [VERTEX_DEPTH];
  int               acc_y [VERTEX_DEPTH];
  int               acc_z [VERTEX_DEPTH];
  int unsigned      hit_cnt [VERTEX_DEPTH];
  int unsigned      idx_old, idx_new;
  longint           pos_old [3];
  longint           pos_new [3];
  bit               flip;
  logic [GAIN_W-1:0] gain;
  normal_word_t     normals_due [$];

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int round_avg(int s, int unsigned h);
    int unsigned m;
    int q;
    m = (s < 0) ? -s : s;
    q = (m + h / 2) / h;
    return (s < 0) ? -q : q;
  endfunction

  function automatic void add_normal(int unsigned idx, int n [3]);
    if (idx >= VERTEX_DEPTH || hit_cnt[idx] >= 255) return;
    acc_x[idx] += n[0];
    acc_y[idx] += n[1];
    acc_z[idx] += n[2];
    hit_cnt[idx]++;
  endfunction

  function automatic void face_normal(int unsigned cur_idx, longint p [3]);
    longint a [3], b [3], e1 [3], e2 [3], c [3];
    longint unsigned mg [3], m, sq, len;
    int n [3];
    int sh;
    for (int k = 0; k < 3; k++) begin
      a[k] = flip ? pos_new[k] : pos_old[k];
      b[k] = flip ? pos_old[k] : pos_new[k];
      e1[k] = b[k] - a[k];
      e2[k] = p[k] - a[k];
    end
    c[0] = e1[1] * e2[2] - e1[2] * e2[1];
    c[1] = e1[2] * e2[0] - e1[0] * e2[2];
    c[2] = (e1[0] * e2[1] - e1[1] * e2[0]) * longint'(gain);
    m = 0;
    for (int k = 0; k < 3; k++) begin
      mg[k] = (c[k] < 0) ? -c[k] : c[k];
      if (mg[k] > m) m = mg[k];
    end
    if (m == 0) return;
    sh = 0;
    while ((m >> sh) >= (64'd1 << 30)) sh++;
    sq = 0;
    for (int k = 0; k < 3; k++) begin
      mg[k] >>= sh;
      sq += mg[k] * mg[k];
    end
    len = int_sqrt(sq);
    if (len == 0) return;
    for (int k = 0; k < 3; k++) begin
      n[k] = int'((mg[k] * 16384 + len / 2) / len);
      if (c[k] < 0) n[k] = -n[k];
    end
    add_normal(idx_old, n);
    add_normal(idx_new, n);
    add_normal(cur_idx, n);
  endfunction

  function automatic void apply_word(logic [IN_DATA_W-1:0] d, logic [IN_USER_W-1:0] u);
    op_t op;
    int unsigned idx, h;
    longint p [3];
    normal_word_t w;
    op = op_t'(u[1:0]);
    idx = d[11:0];
    p[0] = longint'($signed(d[35:12]));
    p[1] = longint'($signed(d[59:36]));
    p[2] = longint'($signed(d[83:60]));
    case (op)
      OP_VERTEX: begin
        if (u[2]) begin
          idx_old = idx;
          idx_new = idx;
          flip = 0;
          pos_old = p;
          pos_new = p;
        end
        if (idx != idx_old) face_normal(idx, p);
        flip = !flip;
        idx_old = idx_new;
        idx_new = idx;
        pos_old = pos_new;
        pos_new = p;
      end
      OP_FINAL: begin
        h = hit_cnt[idx];
        if (h > 1) begin
          acc_x[idx] = round_avg(acc_x[idx], h);
          acc_y[idx] = round_avg(acc_y[idx], h);
          acc_z[idx] = round_avg(acc_z[idx], h);
          hit_cnt[idx] = 1;
        end
        w.nx = acc_x[idx][15:0];
        w.ny = acc_y[idx][15:0];
        w.nz = acc_z[idx][15:0];
        w.hits = h[7:0];
        normals_due.push_back(w);
      end
      OP_CLEAR: begin
        acc_x[idx] = 0;
        acc_y[idx] = 0;
        acc_z[idx] = 0;
        hit_cnt[idx] = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic void report(string what, logic [15:0] e, logic [15:0] a);
    errors++;
    if (errors <= 10)
      $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, e, a);
  endfunction

  always @(posedge clk) begin
    normal_word_t e, a;
    if (!rst_n) begin
      for (int i = 0; i < VERTEX_DEPTH; i++) begin
        acc_x[i] = 0;
        acc_y[i] = 0;
        acc_z[i] = 0;
        hit_cnt[i] = 0;
      end
      idx_old = 0;
      idx_new = 0;
      pos_old = '{0, 0, 0};
      pos_new = '{0, 0, 0};
      flip = 0;
      gain = GAIN_RESET;
      normals_due.delete();
    end else begin
      if (cfg_wr_en) gain = cfg_wr_data;
      if (in_tvalid && in_tready) apply_word(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        a = out_tdata;
        checked++;
        if (normals_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t unexpected output word %h", $realtime, a);
        end else begin
          e = normals_due.pop_front();
          if (e.nx !== a.nx) report("normal_x", e.nx, a.nx);
          if (e.ny !== a.ny) report("normal_y", e.ny, a.ny);
          if (e.nz !== a.nz) report("normal_z", e.nz, a.nz);
          if (e.hits !== a.hits) report("hits_before", e.hits, a.hits);
        end
      end
    end
    pending = normals_due.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    checked = 0;
  end
endmodule
`default_nettype wire

// ===== dv/tb_strip_vertex_normal_accumulator_unit.sv =====
`default_nettype none
module tb_strip_vertex_normal_accumulator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import svna_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 300;

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  cfg_wr_en = 0;
  logic [GAIN_W-1:0]     cfg_wr_data = '0;
  logic                  in_tvalid = 0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // vertex_index, pos_x, pos_y, pos_z, zero pad
  logic [IN_USER_W-1:0]  in_tuser = '0;   // opcode, first_of_strip
  logic                  out_tvalid;
  logic                  out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;       // normal_x, normal_y, normal_z, hits_before
  int                    errors, pending, checked;
  int                    cycles = 0;
  int                    n_vert = 0, n_final = 0, n_clear = 0;
  bit                    calm = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  strip_vertex_normal_accumulator_unit dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata
  );

  svna_normal_checker u_checker (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .errors, .pending, .checked
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d words outstanding", pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side stalls
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1;
      @(negedge clk);
      while (!out_tvalid) @(negedge clk);
      @(posedge clk);
    end
  end

  task automatic send_word(op_t op, bit first, int unsigned idx,
                           int px, int py, int pz);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= {first, op};
    in_tdata  <= {4'b0, pz[23:0], py[23:0], px[23:0], idx[11:0]};
    case (op)
      OP_VERTEX: n_vert++;
      OP_FINAL:  n_final++;
      OP_CLEAR:  n_clear++;
      default: ;
    endcase
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic int rand_pos();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 32'hFFFFFF) << 8) >>> 8;
      1: return int'($urandom_range(0, 2000)) - 1000;
      default: return int'($urandom_range(0, 200000)) - 100000;
    endcase
  endfunction

  task automatic vertex(bit first, int unsigned idx);
    send_word(OP_VERTEX, first, idx, rand_pos(), rand_pos(), rand_pos());
  endtask

  task automatic read_back(int unsigned idx);
    send_word(OP_FINAL, $urandom_range(0, 1), idx, rand_pos(), rand_pos(), rand_pos());
  endtask

  // quiet point: no result owed and no triangle still in flight
  task automatic set_gain(logic [GAIN_W-1:0] g);
    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1;
    cfg_wr_data <= g;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic random_phase(int count);
    int unsigned base, left, roll;
    left = 0;
    base = 0;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        if (left == 0) begin
          left = $urandom_range(3, 12);
          base = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) - 32 : 0;
          if (base > 4095 - 64) base = 4095 - 64;
          vertex(1, base + $urandom_range(0, 63));
        end else begin
          vertex($urandom_range(0, 19) == 0, base + $urandom_range(0, 63));
        end
        left--;
      end else if (roll < 90) begin
        read_back(base + $urandom_range(0, 63));
      end else if (roll < 97) begin
        send_word(OP_CLEAR, $urandom_range(0, 1), base + $urandom_range(0, 63),
                  rand_pos(), rand_pos(), rand_pos());
      end else begin
        send_word(OP_NONE, $urandom_range(0, 1), $urandom_range(0, 4095),
                  rand_pos(), rand_pos(), rand_pos());
      end
      if ($urandom_range(0, 59) == 0) calm = !calm;
    end
    calm = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    set_gain(GAIN_RESET);

    // directed part
    send_word(OP_NONE, 1, 4095, -1, -1, -1);
    send_word(OP_CLEAR, 0, 0, 0, 0, 0);
    read_back(4095);
    send_word(OP_VERTEX, 1, 10, 8388607, 8388607, -8388608);
    send_word(OP_VERTEX, 0, 11, -8388608, 8388607, 8388607);
    send_word(OP_VERTEX, 0, 12, 8388607, -8388608, 8388607);
    send_word(OP_VERTEX, 0, 13, -8388608, -8388608, -8388608);
    // newest repeats oldest: skipped
    send_word(OP_VERTEX, 1, 20, 0, 0, 0);
    send_word(OP_VERTEX, 0, 21, 256, 0, 0);
    send_word(OP_VERTEX, 0, 20, 0, 256, 0);
    // collinear points give a zero vector
    send_word(OP_VERTEX, 1, 30, 0, 0, 0);
    send_word(OP_VERTEX, 0, 31, 1, 1, 1);
    send_word(OP_VERTEX, 0, 32, 2, 2, 2);
    // one entry named twice in a triangle
    send_word(OP_VERTEX, 1, 40, 0, 0, 0);
    send_word(OP_VERTEX, 0, 41, 100, 0, 0);
    send_word(OP_VERTEX, 0, 41, 0, 100, 3);
    read_back(10);
    read_back(12);
    read_back(13);
    read_back(41);
    read_back(40);
    read_back(20);
    send_word(OP_CLEAR, 1, 12, 0, 0, 0);
    read_back(12);

    // hub pattern drives entry 4000 into saturation
    set_gain(15);
    vertex(1, 4000);
    repeat (66) begin
      vertex(0, 4000);
      vertex(0, 4095);
      vertex(0, 4000);
    end
    read_back(4000);
    read_back(4095);
    read_back(4000);

    random_phase(110);
    set_gain(1);
    random_phase(110);
    set_gain(0);
    random_phase(60);
    set_gain($urandom_range(2, 14));
    random_phase(100);

    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("sent %0d strip vertices, %0d finalizes, %0d clears; %0d normals checked",
             n_vert, n_final, n_clear, checked);
    $display("z_gain settings 5, 15, 1, 0 and one random, with hit count saturation");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d normals never returned", errors, pending);
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/svna_pkg.sv
hdl/svna_ram.sv
hdl/svna_div.sv
hdl/strip_vertex_normal_accumulator_unit.sv
dv/svna_normal_checker.sv
dv/tb_strip_vertex_normal_accumulator_unit.sv
